[src/pisf_pkg.sv]
package pisf_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_REFERENCE_SCALE   = 3'd0;
    localparam logic [2:0] REG_INTEGRAL_GAIN     = 3'd1;
    localparam logic [2:0] REG_PROPORTIONAL_GAIN = 3'd2;
    localparam logic [2:0] REG_UPPER_LIMIT       = 3'd3;
    localparam logic [2:0] REG_LOWER_LIMIT       = 3'd4;

    // Fixed state-feedback gains
    localparam logic [31:0] GAIN_CART_VEL = 32'd14344;
    localparam logic [31:0] GAIN_CART_POS = 32'd340;
    localparam logic [31:0] GAIN_ANG_VEL  = 32'hFFFF_998C;  // -26228
    localparam logic [31:0] GAIN_ANG      = 32'hFFFF_AC56;  // -21418

    localparam int PROP_SHIFT    = 6;
    localparam int FB_SHIFT      = 6;
    localparam int ANG_VEL_SHIFT = 3;
    localparam int OUT_SHIFT     = 21;
    localparam int FORCE_W       = 11;

    // Multiplier operand A selects
    localparam logic [2:0] A_REF  = 3'd0;
    localparam logic [2:0] A_ERR  = 3'd1;
    localparam logic [2:0] A_DPOS = 3'd2;
    localparam logic [2:0] A_POS  = 3'd3;
    localparam logic [2:0] A_DANG = 3'd4;
    localparam logic [2:0] A_ANG  = 3'd5;

    // Multiplier operand B selects
    localparam logic [2:0] B_SCALE = 3'd0;
    localparam logic [2:0] B_KI    = 3'd1;
    localparam logic [2:0] B_KP    = 3'd2;
    localparam logic [2:0] B_GCV   = 3'd3;
    localparam logic [2:0] B_GCP   = 3'd4;
    localparam logic [2:0] B_GAV   = 3'd5;
    localparam logic [2:0] B_GA    = 3'd6;

    // Sequencer jump codes
    localparam logic [1:0] J_NEXT     = 2'd0;
    localparam logic [1:0] J_WAIT_IN  = 2'd1;
    localparam logic [1:0] J_WAIT_OUT = 2'd2;
    localparam logic [1:0] J_HOME     = 2'd3;

    localparam int STEP_W = 4;

    // Program steps
    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] ST_MUL_REF  = 4'd1;
    localparam logic [STEP_W-1:0] ST_ERR      = 4'd2;
    localparam logic [STEP_W-1:0] ST_MUL_KI   = 4'd3;
    localparam logic [STEP_W-1:0] ST_MUL_KP   = 4'd4;
    localparam logic [STEP_W-1:0] ST_MUL_GCV  = 4'd5;
    localparam logic [STEP_W-1:0] ST_MUL_GCP  = 4'd6;
    localparam logic [STEP_W-1:0] ST_MUL_GAV  = 4'd7;
    localparam logic [STEP_W-1:0] ST_MUL_GA   = 4'd8;
    localparam logic [STEP_W-1:0] ST_FB_LAST  = 4'd9;
    localparam logic [STEP_W-1:0] ST_SUM      = 4'd10;
    localparam logic [STEP_W-1:0] ST_OUT      = 4'd11;

    typedef struct packed {
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic       mul_en;
        logic       err_ld;
        logic       integ_add;
        logic       acc_ld;
        logic       fb_ld;
        logic       fb_add;
        logic       sum_ld;
        logic       out_ld;
        logic [1:0] jump;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t c;
        c = '0;
        c.jump = J_NEXT;
        case (step)
            ST_IDLE: begin
                c.jump = J_WAIT_IN;
            end
            ST_MUL_REF: begin
                c.a_sel = A_REF;  c.b_sel = B_SCALE; c.mul_en = 1'b1;
            end
            ST_ERR: begin
                c.err_ld = 1'b1;
            end
            ST_MUL_KI: begin
                c.a_sel = A_ERR;  c.b_sel = B_KI;    c.mul_en = 1'b1;
            end
            ST_MUL_KP: begin
                c.integ_add = 1'b1;
                c.a_sel = A_ERR;  c.b_sel = B_KP;    c.mul_en = 1'b1;
            end
            ST_MUL_GCV: begin
                c.acc_ld = 1'b1;
                c.a_sel = A_DPOS; c.b_sel = B_GCV;   c.mul_en = 1'b1;
            end
            ST_MUL_GCP: begin
                c.fb_ld = 1'b1;
                c.a_sel = A_POS;  c.b_sel = B_GCP;   c.mul_en = 1'b1;
            end
            ST_MUL_GAV: begin
                c.fb_add = 1'b1;
                c.a_sel = A_DANG; c.b_sel = B_GAV;   c.mul_en = 1'b1;
            end
            ST_MUL_GA: begin
                c.fb_add = 1'b1;
                c.a_sel = A_ANG;  c.b_sel = B_GA;    c.mul_en = 1'b1;
            end
            ST_FB_LAST: begin
                c.fb_add = 1'b1;
            end
            ST_SUM: begin
                c.sum_ld = 1'b1;
            end
            ST_OUT: begin
                c.out_ld = 1'b1;
                c.jump   = J_WAIT_OUT;
            end
            default: begin
                c.jump = J_HOME;
            end
        endcase
        return c;
    endfunction

endpackage

[src/pisf_sequencer.sv]
module pisf_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_fire,
    input  logic                          out_free,
    output logic [pisf_pkg::STEP_W-1:0]   step,
    output pisf_pkg::ctrl_word_t          ctrl
);

    logic [pisf_pkg::STEP_W-1:0] step_reg;
    logic [pisf_pkg::STEP_W-1:0] step_next;

    assign ctrl = pisf_pkg::ucode(step_reg);
    assign step = step_reg;

    always_comb begin
        step_next = step_reg;
        case (ctrl.jump)
            pisf_pkg::J_NEXT:     step_next = step_reg + 1'b1;
            pisf_pkg::J_WAIT_IN:  if (in_fire) step_next = step_reg + 1'b1;
            pisf_pkg::J_WAIT_OUT: if (out_free) step_next = pisf_pkg::ST_IDLE;
            pisf_pkg::J_HOME:     step_next = pisf_pkg::ST_IDLE;
            default:              step_next = pisf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= pisf_pkg::ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

[src/pisf_datapath.sv]
module pisf_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pisf_pkg::ctrl_word_t               ctrl,
    input  logic                               in_fire,
    input  logic signed [15:0]                 reference_position,
    input  logic signed [31:0]                 cart_pos,
    input  logic signed [15:0]                 pendulum_angle,
    input  logic signed [15:0]                 reference_scale,
    input  logic signed [15:0]                 integral_gain,
    input  logic signed [15:0]                 proportional_gain,
    input  logic signed [31:0]                 upper_limit,
    input  logic signed [31:0]                 lower_limit,
    output logic signed [pisf_pkg::FORCE_W-1:0] force_res
);

    logic [15:0] ref_reg;
    logic [31:0] pos_reg;
    logic [15:0] ang_reg;
    logic [31:0] dpos_reg;
    logic [16:0] dang_reg;
    logic [31:0] prev_pos_reg;
    logic [15:0] prev_ang_reg;
    logic [31:0] integ_reg;
    logic [31:0] err_reg;
    logic [31:0] prod_reg;
    logic [31:0] acc_reg;
    logic [31:0] fb_reg;
    logic [31:0] sum_reg;

    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] clamped;

    always_comb begin
        case (ctrl.a_sel)
            pisf_pkg::A_REF:  op_a = {{16{ref_reg[15]}}, ref_reg};
            pisf_pkg::A_ERR:  op_a = err_reg;
            pisf_pkg::A_DPOS: op_a = dpos_reg;
            pisf_pkg::A_POS:  op_a = pos_reg;
            pisf_pkg::A_DANG: op_a = {{12{dang_reg[16]}}, dang_reg,
                                      {pisf_pkg::ANG_VEL_SHIFT{1'b0}}};
            pisf_pkg::A_ANG:  op_a = {{16{ang_reg[15]}}, ang_reg};
            default:          op_a = '0;
        endcase
    end

    always_comb begin
        case (ctrl.b_sel)
            pisf_pkg::B_SCALE: op_b = {{16{reference_scale[15]}}, reference_scale};
            pisf_pkg::B_KI:    op_b = {{16{integral_gain[15]}}, integral_gain};
            pisf_pkg::B_KP:    op_b = {{16{proportional_gain[15]}}, proportional_gain};
            pisf_pkg::B_GCV:   op_b = pisf_pkg::GAIN_CART_VEL;
            pisf_pkg::B_GCP:   op_b = pisf_pkg::GAIN_CART_POS;
            pisf_pkg::B_GAV:   op_b = pisf_pkg::GAIN_ANG_VEL;
            pisf_pkg::B_GA:    op_b = pisf_pkg::GAIN_ANG;
            default:           op_b = '0;
        endcase
    end

    // Capture the sample; differences against the previous sample are taken here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pos_reg <= '0;
            prev_ang_reg <= '0;
        end else if (in_fire) begin
            prev_pos_reg <= cart_pos;
            prev_ang_reg <= pendulum_angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            ref_reg  <= reference_position;
            pos_reg  <= cart_pos;
            ang_reg  <= pendulum_angle;
            dpos_reg <= cart_pos - prev_pos_reg;
            dang_reg <= {pendulum_angle[15], pendulum_angle}
                      - {prev_ang_reg[15], prev_ang_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else if (ctrl.integ_add) begin
            integ_reg <= integ_reg + prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) prod_reg <= 32'(op_a * op_b);
        if (ctrl.err_ld) err_reg  <= prod_reg - pos_reg;
        if (ctrl.acc_ld) acc_reg  <= prod_reg;
        if (ctrl.fb_ld) begin
            fb_reg <= prod_reg;
        end else if (ctrl.fb_add) begin
            fb_reg <= fb_reg + prod_reg;
        end
        if (ctrl.sum_ld) begin
            sum_reg <= (acc_reg << pisf_pkg::PROP_SHIFT) + integ_reg
                     - (fb_reg << pisf_pkg::FB_SHIFT);
        end
    end

    // Upper bound is checked first, so it wins when the sum is both above the upper and below the lower limit
    always_comb begin
        if ($signed(upper_limit) < $signed(sum_reg)) begin
            clamped = upper_limit;
        end else if ($signed(sum_reg) < $signed(lower_limit)) begin
            clamped = lower_limit;
        end else begin
            clamped = sum_reg;
        end
    end

    assign force_res = clamped[31:pisf_pkg::OUT_SHIFT];

endmodule

[src/pi_state_feedback_controller.sv]
// PI position controller with state feedback for a cart and pendulum.
// Input channel (s_valid/s_ready): one item per sample carries the reference
// position, the measured cart position and the pendulum angle.
// Result channel (m_valid/m_ready): one item per input, the 11-bit force.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// index 0 reference scale, 1 integral gain, 2 proportional gain,
// 3 upper limit, 4 lower limit; other indexes are ignored. Write only idle.
// The microcode program steps one shared 32x32 multiplier through seven
// products plus combine and clamp, and runs the whole program for one item
// before it takes the next.
// The block takes a new input item only with its sequencer on the idle step.
// The result sits in an output register; a stalled receiver holds the program
// on its output step, which stalls the input as well. One more input item can
// be taken and worked on while a finished result waits in the register.
// Reset (aresetn low, synchronous) clears the integrator, the previous
// position and angle, and loads the gains and limits with their defaults.
module pi_state_feedback_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_reference_position,
    input  logic signed [31:0]  s_cart_pos,
    input  logic signed [15:0]  s_pendulum_angle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [10:0]  m_force_res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    pisf_pkg::ctrl_word_t ctrl;
    logic [pisf_pkg::STEP_W-1:0] step;

    logic in_fire;
    logic out_free;
    logic out_load;

    logic signed [15:0] scale_reg;
    logic signed [15:0] ki_reg;
    logic signed [15:0] kp_reg;
    logic signed [31:0] upper_reg;
    logic signed [31:0] lower_reg;

    logic                m_valid_reg;
    logic signed [10:0]  m_force_res_reg;
    logic signed [10:0]  force_value;

    // Accept input only on the idle step
    assign s_ready  = (step == pisf_pkg::ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    // Output slot frees up when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = ctrl.out_ld && out_free;

    assign cfg_ready = 1'b1;

    pisf_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_free (out_free),
        .step     (step),
        .ctrl     (ctrl)
    );

    pisf_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .ctrl               (ctrl),
        .in_fire            (in_fire),
        .reference_position (s_reference_position),
        .cart_pos           (s_cart_pos),
        .pendulum_angle     (s_pendulum_angle),
        .reference_scale    (scale_reg),
        .integral_gain      (ki_reg),
        .proportional_gain  (kp_reg),
        .upper_limit        (upper_reg),
        .lower_limit        (lower_reg),
        .force_res          (force_value)
    );

    // Configuration registers; drop writes to unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= 16'sd1;
            ki_reg    <= '0;
            kp_reg    <= '0;
            upper_reg <= 32'h7FFF_FFFF;
            lower_reg <= 32'h8000_0000;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pisf_pkg::REG_REFERENCE_SCALE:   scale_reg <= cfg_data[15:0];
                pisf_pkg::REG_INTEGRAL_GAIN:     ki_reg    <= cfg_data[15:0];
                pisf_pkg::REG_PROPORTIONAL_GAIN: kp_reg    <= cfg_data[15:0];
                pisf_pkg::REG_UPPER_LIMIT:       upper_reg <= cfg_data;
                pisf_pkg::REG_LOWER_LIMIT:       lower_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Output register: load on the output step, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) m_force_res_reg <= force_value;
    end

    assign m_valid     = m_valid_reg;
    assign m_force_res = m_force_res_reg;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("sequencer stayed idle after taking an item");

    a_result_from_out_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(ctrl.out_ld))
        else $error("result appeared outside the output step");

    a_out_step_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.out_ld && !out_free) |=> (step == pisf_pkg::ST_OUT))
        else $error("program left the output step while the slot was full");
`endif

endmodule
